[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file dxt_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/dxt_pkg.sv]
// shared types, constants and palette helpers for the dxt block decoder
// no dependencies
package dxt_pkg;

  localparam int MAX_ROW_BLOCKS_DEF    = 1024;
  localparam int MAX_COLUMN_BLOCKS_DEF = 1024;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 11;
  localparam int BPR_W       = 11;
  localparam int CNT_W       = 13;
  localparam int COORD_W     = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_FORMAT_MODE    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_PER_ROW = CFG_INDEX_W'(1);

  localparam logic FMT_DXT1 = 1'b0;
  localparam logic FMT_DXT5 = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // channel order: 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [2:0][7:0] rgb_t;
  typedef logic [3:0][3:0][7:0] pal_t;
  typedef logic [7:0][7:0] apal_t;

  typedef struct packed {
    pal_t                pal;
    apal_t               apal;
    logic [31:0]         csel;
    logic [47:0]         asel;
    logic                dxt5;
    logic                last;
    logic [COORD_W-1:0]  base_x;
    logic [COORD_W-1:0]  base_y;
  } block_t;

  function automatic rgb_t expand565(input logic [15:0] c);
    rgb_t e;
    e[0] = {c[15:11], c[15:13]};
    e[1] = {c[10:5], c[10:9]};
    e[2] = {c[4:0], c[4:2]};
    return e;
  endfunction

  // reciprocal multiply, exact for n <= 765
  function automatic logic [7:0] div3(input logic [9:0] n);
    logic [20:0] p;
    p = 21'(n) * 21'(683);
    return p[18:11];
  endfunction

  // reciprocal multiply, exact for n <= 1275
  function automatic logic [7:0] div5(input logic [10:0] n);
    logic [23:0] p;
    p = 24'(n) * 24'(1639);
    return p[20:13];
  endfunction

  // reciprocal multiply, exact for n <= 1785
  function automatic logic [7:0] div7(input logic [10:0] n);
    logic [24:0] p;
    p = 25'(n) * 25'(2341);
    return p[21:14];
  endfunction

endpackage

[hw/rtl/dxt_if.sv]
// channel interfaces of the dxt block decoder: config writes, blocks, pixels
// depends on dxt_pkg
interface dxt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dxt_pkg::CFG_INDEX_W-1:0] index;
  logic [dxt_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface dxt_block_if;
  logic        valid;
  logic        ready;
  logic [15:0] color_endpoint_a;
  logic [15:0] color_endpoint_b;
  logic [31:0] color_selectors;
  logic [7:0]  alpha_endpoint_a;
  logic [7:0]  alpha_endpoint_b;
  logic [47:0] alpha_selectors;
  logic        final_block;
  modport source (output valid, color_endpoint_a, color_endpoint_b, color_selectors,
                  alpha_endpoint_a, alpha_endpoint_b, alpha_selectors, final_block,
                  input ready);
  modport sink   (input valid, color_endpoint_a, color_endpoint_b, color_selectors,
                  alpha_endpoint_a, alpha_endpoint_b, alpha_selectors, final_block,
                  output ready);
endinterface

interface dxt_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  red;
  logic [7:0]                  green;
  logic [7:0]                  blue;
  logic [7:0]                  alpha;
  logic [dxt_pkg::COORD_W-1:0] pixel_x;
  logic [dxt_pkg::COORD_W-1:0] pixel_y;
  logic                        block_done;
  logic                        image_done;
  modport source (output valid, red, green, blue, alpha, pixel_x, pixel_y,
                  block_done, image_done, input ready);
  modport sink   (input valid, red, green, blue, alpha, pixel_x, pixel_y,
                  block_done, image_done, output ready);
endinterface

[hw/rtl/dxt_front.sv]
// front end: config registers, block placement counters, palette build
// depends on dxt_pkg and dxt_if
module dxt_front #(
  parameter int MAX_ROW_BLOCKS    = dxt_pkg::MAX_ROW_BLOCKS_DEF,
  parameter int MAX_COLUMN_BLOCKS = dxt_pkg::MAX_COLUMN_BLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  dxt_cfg_if.sink          cfg,
  dxt_block_if.sink        blocks,
  output logic             q_push,
  output dxt_pkg::block_t  q_data,
  input  logic             q_ready
);

  localparam int CW = (MAX_ROW_BLOCKS > 1) ? $clog2(MAX_ROW_BLOCKS) : 1;
  localparam int RW = (MAX_COLUMN_BLOCKS > 1) ? $clog2(MAX_COLUMN_BLOCKS) : 1;
  localparam int CNT_W = dxt_pkg::CNT_W;

  logic                      format_mode;
  logic [dxt_pkg::BPR_W-1:0] blocks_per_row;
  logic [CW-1:0]             block_column;
  logic [RW-1:0]             block_row;

  // first stage: endpoints, numerators and placement of the block
  logic                        s1_valid;
  dxt_pkg::rgb_t               s1_e0;
  dxt_pkg::rgb_t               s1_e1;
  logic [2:0][9:0]             s1_cn2;
  logic [2:0][9:0]             s1_cn3;
  logic                        s1_four;
  logic [7:0][10:0]            s1_anum;
  logic                        s1_seven;
  logic [7:0]                  s1_a0;
  logic [7:0]                  s1_a1;
  logic [31:0]                 s1_csel;
  logic [47:0]                 s1_asel;
  logic                        s1_dxt5;
  logic                        s1_last;
  logic [dxt_pkg::COORD_W-1:0] s1_base_x;
  logic [dxt_pkg::COORD_W-1:0] s1_base_y;

  logic             accept;
  logic [CNT_W-1:0] row_width;
  logic [CNT_W-1:0] col_inc;
  logic [CNT_W-1:0] row_inc;
  logic [13:0]      x_wide;
  logic [13:0]      y_wide;

  dxt_pkg::rgb_t    e0;
  dxt_pkg::rgb_t    e1;
  logic             four;
  logic             seven;
  logic [2:0][9:0]  cn2;
  logic [2:0][9:0]  cn3;
  logic [7:0][10:0] anum;

  assign cfg.ready    = 1'b1;
  assign blocks.ready = !s1_valid || q_ready;
  assign accept       = blocks.valid && blocks.ready;
  assign q_push       = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode    <= dxt_pkg::FMT_DXT1;
      blocks_per_row <= dxt_pkg::BPR_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        dxt_pkg::REG_FORMAT_MODE:    format_mode    <= cfg.data[0];
        dxt_pkg::REG_BLOCKS_PER_ROW: blocks_per_row <= cfg.data[dxt_pkg::BPR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective row width: zero acts as one, clamp at the bound
  always_comb begin
    if (blocks_per_row == '0) begin
      row_width = CNT_W'(1);
    end else if (CNT_W'(blocks_per_row) > CNT_W'(MAX_ROW_BLOCKS)) begin
      row_width = CNT_W'(MAX_ROW_BLOCKS);
    end else begin
      row_width = CNT_W'(blocks_per_row);
    end
    col_inc = CNT_W'(block_column) + CNT_W'(1);
    row_inc = CNT_W'(block_row) + CNT_W'(1);
    x_wide  = 14'(block_column) << 2;
    y_wide  = 14'(block_row) << 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_column <= '0;
      block_row    <= '0;
    end else if (accept) begin
      if (blocks.final_block) begin
        block_column <= '0;
        block_row    <= '0;
      end else if (col_inc >= row_width) begin
        block_column <= '0;
        if (row_inc >= CNT_W'(MAX_COLUMN_BLOCKS)) begin
          block_row <= '0;
        end else begin
          block_row <= row_inc[RW-1:0];
        end
      end else begin
        block_column <= col_inc[CW-1:0];
      end
    end
  end

  // numerators of the interpolated entries
  always_comb begin
    e0    = dxt_pkg::expand565(blocks.color_endpoint_a);
    e1    = dxt_pkg::expand565(blocks.color_endpoint_b);
    four  = (format_mode == dxt_pkg::FMT_DXT5) ||
            (blocks.color_endpoint_a > blocks.color_endpoint_b);
    seven = blocks.alpha_endpoint_a > blocks.alpha_endpoint_b;
    for (int ch = 0; ch < 3; ch++) begin
      if (four) begin
        cn2[ch] = {1'b0, e0[ch], 1'b0} + 10'(e1[ch]);
        cn3[ch] = 10'(e0[ch]) + {1'b0, e1[ch], 1'b0};
      end else begin
        cn2[ch] = 10'(e0[ch]) + 10'(e1[ch]);
        cn3[ch] = '0;
      end
    end
    anum = '0;
    for (int k = 2; k < 8; k++) begin
      if (seven) begin
        anum[k] = 11'(8 - k) * 11'(blocks.alpha_endpoint_a) +
                  11'(k - 1) * 11'(blocks.alpha_endpoint_b);
      end else if (k < 6) begin
        anum[k] = 11'(6 - k) * 11'(blocks.alpha_endpoint_a) +
                  11'(k - 1) * 11'(blocks.alpha_endpoint_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (q_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_e0     <= e0;
      s1_e1     <= e1;
      s1_cn2    <= cn2;
      s1_cn3    <= cn3;
      s1_four   <= four;
      s1_anum   <= anum;
      s1_seven  <= seven;
      s1_a0     <= blocks.alpha_endpoint_a;
      s1_a1     <= blocks.alpha_endpoint_b;
      s1_csel   <= blocks.color_selectors;
      s1_asel   <= blocks.alpha_selectors;
      s1_dxt5   <= format_mode;
      s1_last   <= blocks.final_block;
      s1_base_x <= x_wide[dxt_pkg::COORD_W-1:0];
      s1_base_y <= y_wide[dxt_pkg::COORD_W-1:0];
    end
  end

  // second half: divide the numerators and pack the queue entry
  always_comb begin
    q_data        = '0;
    q_data.csel   = s1_csel;
    q_data.asel   = s1_asel;
    q_data.dxt5   = s1_dxt5;
    q_data.last   = s1_last;
    q_data.base_x = s1_base_x;
    q_data.base_y = s1_base_y;
    for (int ch = 0; ch < 3; ch++) begin
      q_data.pal[0][ch] = s1_e0[ch];
      q_data.pal[1][ch] = s1_e1[ch];
      q_data.pal[2][ch] = s1_four ? dxt_pkg::div3(s1_cn2[ch]) : s1_cn2[ch][8:1];
      q_data.pal[3][ch] = s1_four ? dxt_pkg::div3(s1_cn3[ch]) : 8'd0;
    end
    q_data.pal[0][3] = dxt_pkg::ALPHA_OPAQUE;
    q_data.pal[1][3] = dxt_pkg::ALPHA_OPAQUE;
    q_data.pal[2][3] = dxt_pkg::ALPHA_OPAQUE;
    q_data.pal[3][3] = s1_four ? dxt_pkg::ALPHA_OPAQUE : 8'd0;
    q_data.apal[0] = s1_a0;
    q_data.apal[1] = s1_a1;
    for (int k = 2; k < 8; k++) begin
      if (s1_seven) begin
        q_data.apal[k] = dxt_pkg::div7(s1_anum[k]);
      end else if (k < 6) begin
        q_data.apal[k] = dxt_pkg::div5(s1_anum[k]);
      end else if (k == 6) begin
        q_data.apal[k] = 8'd0;
      end else begin
        q_data.apal[k] = dxt_pkg::ALPHA_OPAQUE;
      end
    end
  end

endmodule

[hw/rtl/dxt_queue.sv]
// short register queue of decoded block palettes between front and back
// depends on dxt_pkg
module dxt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dxt_pkg::block_t push_data,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output dxt_pkg::block_t pop_data
);

  localparam int DEPTH  = dxt_pkg::QUEUE_DEPTH;
  localparam int PTR_W  = dxt_pkg::QPTR_W;
  localparam int CNT_W  = dxt_pkg::QCNT_W;

  dxt_pkg::block_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[hw/rtl/dxt_back.sv]
// back end: walks the 16 pixels of a block and drives the pixel output register
// depends on dxt_pkg and dxt_if
module dxt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  dxt_pkg::block_t q_data,
  output logic            q_pop,
  dxt_pixel_if.source     pixels
);

  logic                        busy;
  logic [3:0]                  pix_cnt;
  dxt_pkg::pal_t               pal;
  dxt_pkg::apal_t              apal;
  logic [31:0]                 csel;
  logic [47:0]                 asel;
  logic                        dxt5;
  logic                        last;
  logic [dxt_pkg::COORD_W-1:0] base_x;
  logic [dxt_pkg::COORD_W-1:0] base_y;

  logic issue;
  logic load;
  logic last_pix;

  assign last_pix = pix_cnt == 4'd15;
  assign issue    = busy && (!pixels.valid || pixels.ready);
  assign load     = !busy || (issue && last_pix);
  assign q_pop    = load && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pix_cnt      <= '0;
      pixels.valid <= 1'b0;
    end else begin
      if (issue) begin
        pixels.valid <= 1'b1;
      end else if (pixels.ready) begin
        pixels.valid <= 1'b0;
      end
      if (load) begin
        busy    <= q_valid;
        pix_cnt <= '0;
      end else if (issue) begin
        pix_cnt <= pix_cnt + 4'd1;
      end
    end
  end

  // selectors shift down one pixel per issue
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pal    <= q_data.pal;
      apal   <= q_data.apal;
      csel   <= q_data.csel;
      asel   <= q_data.asel;
      dxt5   <= q_data.dxt5;
      last   <= q_data.last;
      base_x <= q_data.base_x;
      base_y <= q_data.base_y;
    end else if (issue) begin
      csel <= csel >> 2;
      asel <= asel >> 3;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pixels.red        <= pal[csel[1:0]][0];
      pixels.green      <= pal[csel[1:0]][1];
      pixels.blue       <= pal[csel[1:0]][2];
      pixels.alpha      <= dxt5 ? apal[asel[2:0]] : pal[csel[1:0]][3];
      pixels.pixel_x    <= {base_x[dxt_pkg::COORD_W-1:2], pix_cnt[1:0]};
      pixels.pixel_y    <= {base_y[dxt_pkg::COORD_W-1:2], pix_cnt[3:2]};
      pixels.block_done <= last_pix;
      pixels.image_done <= last_pix && last;
    end
  end

endmodule

[hw/rtl/dxt_texture_block_decoder_top.sv]
// dxt1 / dxt5 texture block decoder, top level
// depends on dxt_pkg, dxt_if, dxt_front, dxt_queue, dxt_back
//
// channels: cfg takes register writes (index 0 format_mode, 1 blocks_per_row),
// always ready; blocks takes one compressed 4x4 block per transaction; pixels
// gives 16 transactions per block in raster order, each with its image x, y.
// blocks are placed left to right by a column counter that wraps at the
// effective row width; final_block sends both counters back to zero.
// path: a block goes through the front end's stage register, a queue entry
// and the back end's block registers to reach the pixel output register.
// throughput: one pixel per cycle while the pixel receiver is ready and the
// queue holds a block, set by the single pixel output register of the back
// end; the front end builds the next palette while the back end emits the
// current one, with a two-entry queue in between.
// reset (rst, synchronous): counters, queue and output valid clear,
// format_mode returns to dxt1, blocks_per_row to 1.
// when the pixel receiver stalls, the output holds, the queue fills and then
// blocks.ready drops; nothing is lost.
module dxt_texture_block_decoder_top #(
  parameter int MAX_ROW_BLOCKS    = dxt_pkg::MAX_ROW_BLOCKS_DEF,
  parameter int MAX_COLUMN_BLOCKS = dxt_pkg::MAX_COLUMN_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  dxt_cfg_if.sink     cfg,
  dxt_block_if.sink   blocks,
  dxt_pixel_if.source pixels
);

  logic            f_push;
  logic            f_ready;
  dxt_pkg::block_t f_data;
  logic            q_valid;
  logic            q_pop;
  dxt_pkg::block_t q_data;

  dxt_front #(
    .MAX_ROW_BLOCKS    (MAX_ROW_BLOCKS),
    .MAX_COLUMN_BLOCKS (MAX_COLUMN_BLOCKS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .blocks  (blocks),
    .q_push  (f_push),
    .q_data  (f_data),
    .q_ready (f_ready)
  );

  dxt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_data  (f_data),
    .push_ready (f_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  dxt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .pixels  (pixels)
  );

endmodule

[hw/rtl/dxt_checker.sv]
// port-level checks of the dxt block decoder, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module dxt_checker (
  input logic        clk,
  input logic        rst,
  input logic        px_valid,
  input logic        px_ready,
  input logic [11:0] px_x,
  input logic [11:0] px_y,
  input logic [7:0]  px_alpha,
  input logic        px_block_done,
  input logic        px_image_done
);

  property p_stall_hold;
    px_valid && !px_ready |=>
      px_valid && $stable(px_x) && $stable(px_y) && $stable(px_alpha);
  endproperty

  property p_image_in_block;
    px_valid && px_image_done |-> px_block_done;
  endproperty

  property p_done_corner;
    px_valid && px_block_done |-> px_x[1:0] == 2'd3 && px_y[1:0] == 2'd3;
  endproperty

  property p_reset_quiet;
    rst |=> !px_valid;
  endproperty

  `ASSERT_CLKD(a_stall_hold, clk, rst, p_stall_hold, "pixel changed while stalled")
  `ASSERT_CLKD(a_image_in_block, clk, rst, p_image_in_block, "image_done without block_done")
  `ASSERT_CLKD(a_done_corner, clk, rst, p_done_corner, "block_done off the bottom right pixel")
  `ASSERT_ALWAYS(a_reset_quiet, clk, p_reset_quiet, "pixel valid right after reset")

endmodule

bind dxt_texture_block_decoder_top dxt_checker u_dxt_checker (
  .clk           (clk),
  .rst           (rst),
  .px_valid      (pixels.valid),
  .px_ready      (pixels.ready),
  .px_x          (pixels.pixel_x),
  .px_y          (pixels.pixel_y),
  .px_alpha      (pixels.alpha),
  .px_block_done (pixels.block_done),
  .px_image_done (pixels.image_done)
);
